[sv/uoa_pkg.sv]
// package: shared word types and constants for the obstacle avoidance block
`timescale 1ns / 1ps
package uoa_pkg;

  localparam int DIST_W = 20;
  localparam int VEL_W = 32;
  localparam int RATE_W = 31;
  localparam int CFG_W = 31;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_THR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPIN_RATE = 3'd4;

  localparam logic [7:0] PERIOD_RESET = 8'd30;
  localparam logic [DIST_W-1:0] SIDE_THR_RESET = 20'd120;
  localparam logic [DIST_W-1:0] FRONT_THR_RESET = 20'd260;
  localparam logic [RATE_W-1:0] DEADBAND_RESET = 31'd6554;
  localparam logic [RATE_W-1:0] SPIN_RATE_RESET = 31'd1310720;

  typedef struct packed {
    logic [DIST_W-1:0] dist_left;
    logic [DIST_W-1:0] dist_front_a;
    logic [DIST_W-1:0] dist_front_b;
    logic [DIST_W-1:0] dist_right;
    logic signed [VEL_W-1:0] target_v;
    logic signed [VEL_W-1:0] target_omega;
  } in_word_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] new_target_v;
    logic signed [VEL_W-1:0] new_target_omega;
    logic stop_flag;
    logic escaping;
  } out_word_t;

  typedef struct packed {
    logic issue;
    logic full;
  } lane_ctl_t;

  typedef enum logic {
    MODE_AVOID,
    MODE_ESCAPE
  } mode_t;

endpackage

[sv/ultrasonic_obstacle_avoidance_top.sv]
// top level: ultrasonic obstacle avoidance with four window lanes and escape logic
//
// input channel: in_valid / in_stall carry one word per tick with four distances
// and the commanded linear and angular velocity (Q16.16)
// only every decimation_period-th word is processed; it yields one result word
// on out_valid / out_stall, the other words yield nothing
// config: cfg_we writes cfg_data to register cfg_index (0 period, 1 side
// threshold, 2 front threshold, 3 omega deadband, 4 spin rate); the user
// must write only while idle; the block itself does not enforce it
// each result passes window memory read, sum update and merge into output queue
// throughput: one word per cycle while in_stall is low; each lane reads its
// window memory when a processed word is taken and writes it in the next cycle
// a four-word output queue absorbs receiver stalls; in_stall rises only when
// queued plus in-flight results fill it
// reset: registers take their defaults, windows start empty, no clearing pass
`timescale 1ns / 1ps
module ultrasonic_obstacle_avoidance_top #(
  parameter int WINDOW = 10,
  parameter int DIST_BITS = 20
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  uoa_pkg::in_word_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output uoa_pkg::out_word_t out_data,
  input  logic cfg_we,
  input  logic [uoa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [uoa_pkg::CFG_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [7:0] period;
  logic [uoa_pkg::DIST_W-1:0] side_thr;
  logic [uoa_pkg::DIST_W-1:0] front_thr;
  logic [uoa_pkg::RATE_W-1:0] deadband;
  logic [uoa_pkg::RATE_W-1:0] spin_rate;

  logic [7:0] tick_count;
  logic [7:0] tick_inc;
  logic proc;
  logic accept;
  logic issue;

  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] fill_new;
  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] write_slot_next;
  logic full;

  uoa_pkg::lane_ctl_t lane_ctl;
  logic [uoa_pkg::DIST_W-1:0] lane_dist [4];
  logic [uoa_pkg::DIST_W-1:0] lane_thr [4];
  logic [3:0] blk;

  logic vb;
  logic vc;
  logic signed [uoa_pkg::VEL_W-1:0] v_b;
  logic signed [uoa_pkg::VEL_W-1:0] w_b;
  logic signed [uoa_pkg::VEL_W-1:0] v_c;
  logic signed [uoa_pkg::VEL_W-1:0] w_c;

  uoa_pkg::out_word_t result;
  logic [uoa_pkg::OUT_CNT_W-1:0] q_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= uoa_pkg::PERIOD_RESET;
      side_thr <= uoa_pkg::SIDE_THR_RESET;
      front_thr <= uoa_pkg::FRONT_THR_RESET;
      deadband <= uoa_pkg::DEADBAND_RESET;
      spin_rate <= uoa_pkg::SPIN_RATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        uoa_pkg::REG_PERIOD: period <= cfg_data[7:0];
        uoa_pkg::REG_SIDE_THR: side_thr <= cfg_data[uoa_pkg::DIST_W-1:0];
        uoa_pkg::REG_FRONT_THR: front_thr <= cfg_data[uoa_pkg::DIST_W-1:0];
        uoa_pkg::REG_DEADBAND: deadband <= cfg_data[uoa_pkg::RATE_W-1:0];
        uoa_pkg::REG_SPIN_RATE: spin_rate <= cfg_data[uoa_pkg::RATE_W-1:0];
        default: period <= period;
      endcase
    end
  end

  // credit check against the output queue
  assign in_stall = (q_count + uoa_pkg::OUT_CNT_W'(vb) + uoa_pkg::OUT_CNT_W'(vc))
                    >= uoa_pkg::OUT_CNT_W'(uoa_pkg::OUT_DEPTH);
  assign accept = in_valid && !in_stall;
  assign tick_inc = tick_count + 8'd1;
  assign proc = tick_inc >= period;
  assign issue = accept && proc;

  assign full = fill_count == CNT_W'(WINDOW);
  assign fill_new = full ? fill_count : fill_count + CNT_W'(1);
  assign write_slot_next = (write_slot == SLOT_W'(WINDOW - 1)) ? '0
                           : write_slot + SLOT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      fill_count <= '0;
      write_slot <= '0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (accept) begin
        tick_count <= proc ? 8'd0 : tick_inc;
      end
      if (issue) begin
        fill_count <= fill_new;
        write_slot <= write_slot_next;
      end
      vb <= issue;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      v_b <= in_data.target_v;
      w_b <= in_data.target_omega;
    end
    if (vb) begin
      v_c <= v_b;
      w_c <= w_b;
    end
  end

  assign lane_ctl.issue = issue;
  assign lane_ctl.full = full;
  assign lane_dist[0] = in_data.dist_left;
  assign lane_dist[1] = in_data.dist_front_a;
  assign lane_dist[2] = in_data.dist_front_b;
  assign lane_dist[3] = in_data.dist_right;
  assign lane_thr[0] = side_thr;
  assign lane_thr[1] = front_thr;
  assign lane_thr[2] = front_thr;
  assign lane_thr[3] = side_thr;

  for (genvar i = 0; i < 4; i++) begin : g_lane
    uoa_lane #(
      .WINDOW(WINDOW),
      .DIST_BITS(DIST_BITS)
    ) u_lane (
      .clk(clk),
      .rst(rst),
      .ctl(lane_ctl),
      .slot(write_slot),
      .fill(fill_new),
      .sample(lane_dist[i]),
      .thr(lane_thr[i]),
      .blocked(blk[i])
    );
  end

  uoa_merge u_merge (
    .clk(clk),
    .rst(rst),
    .step(vc),
    .blk(blk),
    .v(v_c),
    .w(w_c),
    .deadband(deadband),
    .spin_rate(spin_rate),
    .result(result)
  );

  uoa_out_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(vc),
    .push_data(result),
    .valid(out_valid),
    .stall(out_stall),
    .data(out_data),
    .count(q_count)
  );

endmodule

[sv/uoa_lane.sv]
// lane: sliding window of one distance channel, window sum and threshold test
`timescale 1ns / 1ps
module uoa_lane #(
  parameter int WINDOW = 10,
  parameter int DIST_BITS = 20
) (
  input  logic clk,
  input  logic rst,
  input  uoa_pkg::lane_ctl_t ctl,
  input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] slot,
  input  logic [$clog2(WINDOW + 1)-1:0] fill,
  input  logic [uoa_pkg::DIST_W-1:0] sample,
  input  logic [uoa_pkg::DIST_W-1:0] thr,
  output logic blocked
);

  localparam int DW = (DIST_BITS < uoa_pkg::DIST_W) ? DIST_BITS : uoa_pkg::DIST_W;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W = DW + CNT_W;
  localparam int PROD_W = uoa_pkg::DIST_W + CNT_W;

  logic [DW-1:0] mem [WINDOW];
  logic [DW-1:0] rdata;

  logic b_valid;
  logic [DW-1:0] b_d;
  logic [SLOT_W-1:0] b_slot;
  logic b_full;
  logic b_hit;
  logic [DW-1:0] b_fwd;
  logic [PROD_W-1:0] b_prod;
  logic [PROD_W-1:0] c_prod;

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_next;
  logic [DW-1:0] old;

  // window memory: read the oldest entry at issue, write the new one in the next cycle
  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      rdata <= mem[slot];
    end
    if (b_valid) begin
      mem[b_slot] <= b_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= ctl.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      b_d <= sample[DW-1:0];
      b_slot <= slot;
      b_full <= ctl.full;
      b_hit <= b_valid && (b_slot == slot);
      b_fwd <= b_d;
      b_prod <= PROD_W'(thr) * PROD_W'(fill);
    end
    if (b_valid) begin
      c_prod <= b_prod;
    end
  end

  // same-cycle write bypass
  assign old = b_hit ? b_fwd : rdata;

  always_comb begin
    sum_next = sum + SUM_W'(b_d);
    if (b_full) begin
      sum_next = sum_next - SUM_W'(old);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (b_valid) begin
      sum <= sum_next;
    end
  end

  assign blocked = PROD_W'(sum) < c_prod;

endmodule

[sv/uoa_merge.sv]
// merge: combines lane results and runs the avoid or escape state machine
`timescale 1ns / 1ps
module uoa_merge (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  logic [3:0] blk,
  input  logic signed [uoa_pkg::VEL_W-1:0] v,
  input  logic signed [uoa_pkg::VEL_W-1:0] w,
  input  logic [uoa_pkg::RATE_W-1:0] deadband,
  input  logic [uoa_pkg::RATE_W-1:0] spin_rate,
  output uoa_pkg::out_word_t result
);

  uoa_pkg::mode_t mode;
  uoa_pkg::mode_t mode_next;
  logic vel_active;
  logic vel_active_next;
  logic omega_active;
  logic omega_active_next;
  logic stop_held;
  logic stop_held_next;
  logic signed [uoa_pkg::VEL_W-1:0] omega_backup;
  logic signed [uoa_pkg::VEL_W-1:0] omega_backup_next;

  logic left;
  logic mid;
  logic right;
  logic any_blk;
  logic moving;
  logic turn_pos;
  logic turn_neg;
  logic ccw_spin;
  logic signed [uoa_pkg::VEL_W:0] w_ext;
  logic signed [uoa_pkg::VEL_W:0] db_ext;
  logic signed [uoa_pkg::VEL_W-1:0] spin_pos;

  assign left = blk[0];
  assign mid = blk[1] | blk[2];
  assign right = blk[3];
  assign any_blk = left | mid | right;
  assign moving = v > 32'sd0;
  assign w_ext = {w[uoa_pkg::VEL_W-1], w};
  assign db_ext = {2'b00, deadband};
  assign turn_pos = w_ext > db_ext;
  assign turn_neg = w_ext < -db_ext;
  assign omega_backup_next = stop_held ? omega_backup : w;
  assign spin_pos = {1'b0, spin_rate};

  always_comb begin
    if (!left && !mid) begin
      ccw_spin = 1'b1;
    end else if (!right && !mid) begin
      ccw_spin = 1'b0;
    end else begin
      ccw_spin = !omega_backup_next[uoa_pkg::VEL_W-1];
    end
  end

  // flag updates
  always_comb begin
    vel_active_next = vel_active;
    omega_active_next = omega_active;
    stop_held_next = stop_held;
    if (!any_blk) begin
      stop_held_next = 1'b0;
    end else if (mode == uoa_pkg::MODE_AVOID) begin
      if (turn_pos || turn_neg) begin
        omega_active_next = 1'b1;
        if (moving) begin
          vel_active_next = 1'b1;
          if (turn_pos ? left : right) begin
            stop_held_next = 1'b1;
            omega_active_next = 1'b0;
          end
          if (mid) begin
            stop_held_next = 1'b1;
            vel_active_next = 1'b0;
          end
          if (turn_pos ? right : left) begin
            stop_held_next = 1'b0;
          end
        end else begin
          stop_held_next = 1'b0;
        end
      end else begin
        omega_active_next = 1'b0;
        if (moving) begin
          stop_held_next = 1'b1;
          vel_active_next = 1'b0;
        end else begin
          stop_held_next = 1'b0;
        end
      end
    end else begin
      stop_held_next = 1'b1;
    end
  end

  // next state
  always_comb begin
    mode_next = mode;
    unique case (mode)
      uoa_pkg::MODE_AVOID: begin
        if (any_blk && !vel_active_next && !omega_active_next && stop_held_next) begin
          mode_next = uoa_pkg::MODE_ESCAPE;
        end
      end
      uoa_pkg::MODE_ESCAPE: begin
        if (!any_blk) begin
          mode_next = uoa_pkg::MODE_AVOID;
        end
      end
      default: mode_next = uoa_pkg::MODE_AVOID;
    endcase
  end

  // outputs
  always_comb begin
    result.new_target_v = v;
    result.new_target_omega = w;
    result.stop_flag = stop_held_next;
    result.escaping = (mode_next == uoa_pkg::MODE_ESCAPE);
    if (any_blk) begin
      unique case (mode)
        uoa_pkg::MODE_AVOID: begin
          if ((turn_pos || turn_neg) && moving) begin
            if (turn_pos ? left : right) begin
              result.new_target_omega = '0;
            end
            if (mid) begin
              result.new_target_v = '0;
            end
          end
        end
        uoa_pkg::MODE_ESCAPE: begin
          result.new_target_v = '0;
          result.new_target_omega = ccw_spin ? spin_pos : -spin_pos;
        end
        default: result.new_target_v = v;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= uoa_pkg::MODE_AVOID;
      vel_active <= 1'b0;
      omega_active <= 1'b0;
      stop_held <= 1'b0;
      omega_backup <= '0;
    end else if (step) begin
      mode <= mode_next;
      vel_active <= vel_active_next;
      omega_active <= omega_active_next;
      stop_held <= stop_held_next;
      omega_backup <= omega_backup_next;
    end
  end

endmodule

[sv/uoa_out_queue.sv]
// output queue: small word buffer between the merge stage and the result channel
`timescale 1ns / 1ps
module uoa_out_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  uoa_pkg::out_word_t push_data,
  output logic valid,
  input  logic stall,
  output uoa_pkg::out_word_t data,
  output logic [uoa_pkg::OUT_CNT_W-1:0] count
);

  uoa_pkg::out_word_t slots [uoa_pkg::OUT_DEPTH];
  logic [uoa_pkg::OUT_PTR_W-1:0] head;
  logic [uoa_pkg::OUT_PTR_W-1:0] tail;
  logic pop;

  assign valid = count != '0;
  assign pop = valid && !stall;
  assign data = slots[head];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + 1'b1;
      end
      if (pop) begin
        head <= head + 1'b1;
      end
      count <= count + uoa_pkg::OUT_CNT_W'(push) - uoa_pkg::OUT_CNT_W'(pop);
    end
  end

endmodule

[verif/uoa_avoid_checker.sv]
// checker: predicts the avoidance result words and compares them on the output channel
`timescale 1ns / 1ps
module uoa_avoid_checker #(
  parameter int WINDOW = 10
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  uoa_pkg::in_word_t in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  uoa_pkg::out_word_t out_data,
  input  logic cfg_we,
  input  logic [uoa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [uoa_pkg::CFG_W-1:0] cfg_data,
  output int errs,
  output int pending
);

  logic [7:0] period;
  logic [uoa_pkg::DIST_W-1:0] side_thr;
  logic [uoa_pkg::DIST_W-1:0] front_thr;
  logic [uoa_pkg::RATE_W-1:0] deadband;
  logic [uoa_pkg::RATE_W-1:0] spin;

  logic [7:0] ticks;
  uoa_pkg::mode_t mode;
  logic lin_on;
  logic ang_on;
  logic halt;
  logic signed [uoa_pkg::VEL_W-1:0] rate_saved;
  logic [uoa_pkg::DIST_W-1:0] hist [4][WINDOW];
  logic [63:0] acc [4];
  int held;
  int slot;

  uoa_pkg::out_word_t expected_words [$];
  uoa_pkg::out_word_t want;
  int fail_cnt = 0;

  task automatic avoid_step(input uoa_pkg::in_word_t w);
    logic [7:0] nxt;
    longint v;
    longint om;
    longint db;
    logic [uoa_pkg::DIST_W-1:0] d [4];
    logic [63:0] thr;
    logic blk [4];
    logic lft;
    logic mid;
    logic rgt;
    logic ccw;
    logic cut_side;
    logic free_side;
    uoa_pkg::out_word_t r;
    nxt = ticks + 8'd1;
    if (nxt < period) begin
      ticks = nxt;
      return;
    end
    ticks = '0;
    v = longint'(signed'(w.target_v));
    om = longint'(signed'(w.target_omega));
    if (!halt) rate_saved = w.target_omega;
    d[0] = w.dist_left;
    d[1] = w.dist_front_a;
    d[2] = w.dist_front_b;
    d[3] = w.dist_right;
    for (int c = 0; c < 4; c++) begin
      if (held < WINDOW) acc[c] = acc[c] + d[c];
      else acc[c] = acc[c] - hist[c][slot] + d[c];
      hist[c][slot] = d[c];
    end
    if (held < WINDOW) held++;
    slot = (slot + 1) % WINDOW;
    for (int c = 0; c < 4; c++) begin
      thr = (c == 0 || c == 3) ? 64'(side_thr) : 64'(front_thr);
      blk[c] = acc[c] < thr * 64'(held);
    end
    lft = blk[0];
    mid = blk[1] | blk[2];
    rgt = blk[3];
    db = longint'(deadband);

    if (!(lft || mid || rgt)) begin
      halt = 1'b0;
      mode = uoa_pkg::MODE_AVOID;
    end else if (mode == uoa_pkg::MODE_AVOID) begin
      if (om > db || om < -db) begin
        ccw = om > db;
        ang_on = 1'b1;
        if (v > 0) begin
          cut_side = ccw ? lft : rgt;
          free_side = ccw ? rgt : lft;
          lin_on = 1'b1;
          if (cut_side) begin
            halt = 1'b1;
            om = 0;
            ang_on = 1'b0;
          end
          if (mid) begin
            halt = 1'b1;
            v = 0;
            lin_on = 1'b0;
          end
          if (free_side) halt = 1'b0;
        end else begin
          halt = 1'b0;
        end
      end else begin
        ang_on = 1'b0;
        if (v > 0) begin
          halt = 1'b1;
          lin_on = 1'b0;
        end else begin
          halt = 1'b0;
        end
      end
      if (!lin_on && !ang_on && halt) mode = uoa_pkg::MODE_ESCAPE;
    end else begin
      // escape spin: prefer ccw, else the free side, else the saved rate sign
      if (!lft && !mid) ccw = 1'b1;
      else if (!rgt && !mid) ccw = 1'b0;
      else ccw = (rate_saved >= 0);
      halt = 1'b1;
      v = 0;
      om = ccw ? longint'(spin) : -longint'(spin);
    end

    r.new_target_v = v[31:0];
    r.new_target_omega = om[31:0];
    r.stop_flag = halt;
    r.escaping = (mode == uoa_pkg::MODE_ESCAPE);
    expected_words.push_back(r);
  endtask

  task automatic cmp_field(input string nm, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      fail_cnt++;
      if (fail_cnt <= 100) $error("%s: expected %0d, got %0d", nm, $signed(e), $signed(a));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      period = uoa_pkg::PERIOD_RESET;
      side_thr = uoa_pkg::SIDE_THR_RESET;
      front_thr = uoa_pkg::FRONT_THR_RESET;
      deadband = uoa_pkg::DEADBAND_RESET;
      spin = uoa_pkg::SPIN_RATE_RESET;
      ticks = '0;
      mode = uoa_pkg::MODE_AVOID;
      lin_on = 1'b0;
      ang_on = 1'b0;
      halt = 1'b0;
      rate_saved = '0;
      for (int c = 0; c < 4; c++) acc[c] = '0;
      held = 0;
      slot = 0;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          uoa_pkg::REG_PERIOD: period = cfg_data[7:0];
          uoa_pkg::REG_SIDE_THR: side_thr = cfg_data[uoa_pkg::DIST_W-1:0];
          uoa_pkg::REG_FRONT_THR: front_thr = cfg_data[uoa_pkg::DIST_W-1:0];
          uoa_pkg::REG_DEADBAND: deadband = cfg_data[uoa_pkg::RATE_W-1:0];
          uoa_pkg::REG_SPIN_RATE: spin = cfg_data[uoa_pkg::RATE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) avoid_step(in_data);
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 100) $error("result word with no expectation waiting");
        end else begin
          want = expected_words.pop_front();
          cmp_field("new_target_v", want.new_target_v, out_data.new_target_v);
          cmp_field("new_target_omega", want.new_target_omega, out_data.new_target_omega);
          cmp_field("stop_flag", 32'(want.stop_flag), 32'(out_data.stop_flag));
          cmp_field("escaping", 32'(want.escaping), 32'(out_data.escaping));
        end
      end
    end
    errs <= fail_cnt;
    pending <= expected_words.size();
  end

endmodule

[verif/tb_ultrasonic_obstacle_avoidance_top.sv]
// testbench top: drives ticks and register writes into the avoidance block and gives the verdict
`timescale 1ns / 1ps
module tb_ultrasonic_obstacle_avoidance_top;

  localparam int WINDOW = 10;
  localparam logic [uoa_pkg::DIST_W-1:0] DIST_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  uoa_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  uoa_pkg::out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [uoa_pkg::CFG_IDX_W-1:0] cfg_index = uoa_pkg::REG_PERIOD;
  logic [uoa_pkg::CFG_W-1:0] cfg_data = '0;
  int errs;
  int pending;

  logic quiet = 1'b0;
  logic [uoa_pkg::DIST_W-1:0] cur_side = uoa_pkg::SIDE_THR_RESET;
  logic [uoa_pkg::DIST_W-1:0] cur_front = uoa_pkg::FRONT_THR_RESET;
  logic [uoa_pkg::RATE_W-1:0] cur_db = uoa_pkg::DEADBAND_RESET;
  logic bias [4] = '{default: 1'b0};
  int stall_left = 0;

  ultrasonic_obstacle_avoidance_top #(
    .WINDOW(WINDOW),
    .DIST_BITS(uoa_pkg::DIST_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  uoa_avoid_checker #(
    .WINDOW(WINDOW)
  ) chk (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .errs(errs),
    .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("tb_ultrasonic_obstacle_avoidance_top: done, errors");
    $finish;
  end

  // receiver backpressure: runs of stall or no stall, mostly short
  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      out_stall <= ($urandom_range(99) < 35);
      stall_left = ($urandom_range(15) == 0) ? $urandom_range(60, 20) : $urandom_range(3, 0);
    end
  end

  task automatic send_tick(input uoa_pkg::in_word_t w);
    int gap;
    int r;
    r = $urandom_range(99);
    if (quiet || r < 50) gap = 0;
    else if (r < 94) gap = $urandom_range(3, 1);
    else gap = $urandom_range(40, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [uoa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [uoa_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  function automatic uoa_pkg::in_word_t mk(input logic [uoa_pkg::DIST_W-1:0] l,
                                           input logic [uoa_pkg::DIST_W-1:0] fa,
                                           input logic [uoa_pkg::DIST_W-1:0] fb,
                                           input logic [uoa_pkg::DIST_W-1:0] r,
                                           input logic [31:0] v, input logic [31:0] om);
    uoa_pkg::in_word_t w;
    w.dist_left = l;
    w.dist_front_a = fa;
    w.dist_front_b = fb;
    w.dist_right = r;
    w.target_v = v;
    w.target_omega = om;
    return w;
  endfunction

  // distance below the threshold when near is set, else at or a little above it; one pick in ten is any value
  function automatic logic [uoa_pkg::DIST_W-1:0] pick_dist(
      input logic [uoa_pkg::DIST_W-1:0] thr, input logic near);
    int unsigned hi;
    if ($urandom_range(9) == 0) return uoa_pkg::DIST_W'($urandom);
    if (near) return (thr == 0) ? '0 : uoa_pkg::DIST_W'($urandom_range(thr - 1, 0));
    hi = thr + thr / 2 + 64;
    if (hi > DIST_MAX) hi = DIST_MAX;
    return uoa_pkg::DIST_W'($urandom_range(hi, thr));
  endfunction

  function automatic uoa_pkg::in_word_t rand_word();
    uoa_pkg::in_word_t w;
    longint db;
    longint t;
    for (int c = 0; c < 4; c++) if ($urandom_range(6) == 0) bias[c] = ~bias[c];
    w.dist_left = pick_dist(cur_side, bias[0]);
    w.dist_front_a = pick_dist(cur_front, bias[1]);
    w.dist_front_b = pick_dist(cur_front, bias[2]);
    w.dist_right = pick_dist(cur_side, bias[3]);
    db = longint'(cur_db);
    t = longint'($urandom_range(200000, 0));
    case ($urandom_range(9))
      0: w.target_omega = '0;
      1: w.target_omega = db[31:0];
      2: w.target_omega = 32'(-db);
      3: w.target_omega = 32'(db + 1);
      4: w.target_omega = 32'(-(db + 1));
      5, 6: w.target_omega = $urandom_range(1) ? t[31:0] : 32'(-t);
      7: w.target_omega = $urandom;
      8: w.target_omega = 32'h7fff_ffff;
      default: w.target_omega = 32'h8000_0000;
    endcase
    case ($urandom_range(9))
      0: w.target_v = '0;
      1, 2, 3, 4, 5: w.target_v = $urandom_range(300000, 1);
      6: w.target_v = 32'(-longint'($urandom_range(300000, 1)));
      7: w.target_v = $urandom;
      8: w.target_v = 32'h7fff_ffff;
      default: w.target_v = 32'h8000_0000;
    endcase
    return w;
  endfunction

  task automatic run_phase(input int p);
    int n;
    logic [7:0] per;
    logic [uoa_pkg::DIST_W-1:0] s;
    logic [uoa_pkg::DIST_W-1:0] f;
    logic [uoa_pkg::RATE_W-1:0] db;
    logic [uoa_pkg::RATE_W-1:0] sp;
    n = 90;
    per = 8'($urandom_range(4, 1));
    if ($urandom_range(4) == 0) per = 8'($urandom_range(8, 0));
    s = uoa_pkg::DIST_W'($urandom_range(2000, 0));
    f = uoa_pkg::DIST_W'($urandom_range(4000, 0));
    db = uoa_pkg::RATE_W'($urandom_range(300000, 0));
    sp = uoa_pkg::RATE_W'($urandom);
    case (p)
      1: begin
        per = 8'd1;
        s = '0;
        f = '0;
        db = '0;
        sp = '1;
      end
      2: begin
        per = 8'd2;
        s = DIST_MAX;
        f = DIST_MAX;
        db = '1;
        sp = '0;
      end
      3: per = 8'd30;
      4: begin
        per = 8'd255;
        n = 256;
      end
      default: ;
    endcase
    quiet <= (p % 4 == 1);
    settle();
    if (p != 0) begin
      write_reg(uoa_pkg::REG_PERIOD, uoa_pkg::CFG_W'(per));
      write_reg(uoa_pkg::REG_SIDE_THR, uoa_pkg::CFG_W'(s));
      write_reg(uoa_pkg::REG_FRONT_THR, uoa_pkg::CFG_W'(f));
      write_reg(uoa_pkg::REG_DEADBAND, uoa_pkg::CFG_W'(db));
      write_reg(uoa_pkg::REG_SPIN_RATE, uoa_pkg::CFG_W'(sp));
      cfg_we <= 1'b0;
      cur_side = s;
      cur_front = f;
      cur_db = db;
    end
    repeat (n) send_tick(rand_word());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset period keeps these from being processed
    repeat (12) send_tick(mk(DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX, 32'h0001_0000, '0));
    settle();
    // period lowered below the tick count
    write_reg(uoa_pkg::REG_PERIOD, uoa_pkg::CFG_W'(5));
    cfg_we <= 1'b0;
    send_tick(mk('0, '0, '0, '0, 32'h0001_0000, '0));
    settle();
    // zero period, every tick processed
    write_reg(uoa_pkg::REG_PERIOD, '0);
    cfg_we <= 1'b0;
    send_tick(mk('0, '0, '0, '0, 32'd5, -32'sd7));
    send_tick(mk('0, DIST_MAX, DIST_MAX, '0, 32'd1, '0));
    send_tick(mk(DIST_MAX, DIST_MAX, DIST_MAX, '0, 32'd1, '0));
    send_tick(mk(DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX, 32'h8000_0000, 32'h7fff_ffff));
    send_tick(mk(DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX, 32'h7fff_ffff, 32'h8000_0000));
    send_tick(mk(20'h55555, 20'haaaaa, 20'h55555, 20'haaaaa, '0, 32'd6554));
    send_tick(mk(20'haaaaa, 20'h55555, 20'haaaaa, 20'h55555, 32'd1, 32'd6555));
    send_tick(mk(20'd1, 20'd1, 20'd1, 20'd1, '0, -32'sd6555));
    send_tick(mk('0, '0, '0, '0, 32'hffff_ffff, -32'sd6554));

    for (int p = 0; p < 13; p++) run_phase(p);
    settle();
    repeat (20) @(posedge clk);
    if (errs == 0) begin
      $display("tb_ultrasonic_obstacle_avoidance_top: done, clean");
    end else begin
      $display("tb_ultrasonic_obstacle_avoidance_top: done, errors");
    end
    $finish;
  end

endmodule
